@@ rtl/core/quaternion_arith_unit_core_defines.svh @@
// Assertion helpers shared by the core RTL
`ifndef QUATERNION_ARITH_UNIT_CORE_DEFINES_SVH
`define QUATERNION_ARITH_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define QAU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define QAU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/qau_pkg.sv @@
`default_nettype none
package qau_pkg;

    // Fixed-point format and derived widths
    localparam int FRAC_BITS  = 28;
    localparam int Q_W        = 32;
    localparam int MOD_W      = 36;
    localparam int OP_W       = 3;
    localparam int PROD_W     = 2 * Q_W;
    localparam int ACC_W      = PROD_W + 4;
    localparam int SS_W       = PROD_W + 1;
    localparam int REM_W      = SS_W + 1;
    localparam int QB_W       = Q_W + 2;
    localparam int NUM_W      = Q_W + 2 * FRAC_BITS + 1;
    localparam int SQRT_STEPS = PROD_W / 2;
    localparam int SQ_CW      = $clog2(SQRT_STEPS + 1);
    localparam int DV_CW      = $clog2(QB_W + 1);
    localparam int IN_DATA_W  = 5 * Q_W;
    localparam int OUT_DATA_W = ((4 * Q_W + MOD_W + 7) / 8) * 8;

    localparam logic signed [Q_W-1:0] FIX_ONE = Q_W'(64'd1 << FRAC_BITS);
    localparam logic signed [Q_W-1:0] Q_MAX   = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN   = {1'b1, {(Q_W-1){1'b0}}};

    typedef enum logic [OP_W-1:0] {
        OP_LOAD       = 3'd0,
        OP_ADD_SCALED = 3'd1,
        OP_MUL        = 3'd2,
        OP_PREMUL     = 3'd3,
        OP_CONJ       = 3'd4,
        OP_SCALE      = 3'd5,
        OP_RECIP      = 3'd6,
        OP_NORM       = 3'd7
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SIMPLE,
        S_MAC_ISSUE,
        S_MAC_WAIT,
        S_MAC_DONE,
        S_SQRT,
        S_DIV_START,
        S_DIV_RUN,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        JOB_COMP,
        JOB_SSOLD,
        JOB_MOD
    } job_t;

    typedef struct packed {
        logic start;
        logic issue;
        logic neg;
    } mac_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // Hamilton product term tables: left index, right index, negate mask
    localparam logic [1:0] HAM_IA [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd2, 2'd3, 2'd1},
        '{2'd0, 2'd3, 2'd1, 2'd2}
    };
    localparam logic [1:0] HAM_IB [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd2, 2'd0, 2'd1, 2'd3},
        '{2'd3, 2'd0, 2'd2, 2'd1}
    };
    localparam logic [3:0] HAM_NEG [4] = '{4'b1110, 4'b1000, 4'b1000, 4'b1000};

endpackage
`default_nettype wire

@@ rtl/core/qau_mac.sv @@
`default_nettype none
module qau_mac
    import qau_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire mac_ctl_t                ctl,
    input  wire logic signed [Q_W-1:0]   op_a,
    input  wire logic signed [Q_W-1:0]   op_b,
    output logic signed [ACC_W-1:0]      acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     neg_reg;
    logic                     pend_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  term;

    // Register one product per issue beat
    always_ff @(posedge clk)
    begin
        if (ctl.issue)
        begin
            prod_reg <= op_a * op_b;
            neg_reg  <= ctl.neg;
        end
    end

    // Add the pending product, signed, into the sum
    always_comb
    begin
        term = '0;
        if (pend_reg)
        begin
            term = neg_reg ? -ACC_W'(prod_reg) : ACC_W'(prod_reg);
        end
        acc_next = (ctl.start ? '0 : acc_reg) + term;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            acc_reg  <= '0;
        end
        else
        begin
            pend_reg <= ctl.issue;
            acc_reg  <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule
`default_nettype wire

@@ rtl/core/qau_sqrt.sv @@
`default_nettype none
module qau_sqrt
    import qau_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [PROD_W-1:0] x,
    output unit_stat_t             stat,
    output logic [Q_W-1:0]         root
);

    logic [PROD_W-1:0] rem_reg;
    logic [PROD_W-1:0] res_reg;
    logic [PROD_W-1:0] bit_reg;
    logic [SQ_CW-1:0]  cnt_reg;
    logic              done_reg;
    logic [PROD_W-1:0] trial;
    logic              take;

    assign trial = res_reg + bit_reg;
    assign take  = rem_reg >= trial;

    // One result bit per beat, two radicand bits consumed
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= x;
            res_reg <= '0;
            bit_reg <= {2'b01, {(PROD_W-2){1'b0}}};
        end
        else if (cnt_reg != '0)
        begin
            if (take)
            begin
                rem_reg <= rem_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= SQ_CW'(SQRT_STEPS);
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == SQ_CW'(1));
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - SQ_CW'(1);
            end
        end
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign root      = res_reg[Q_W-1:0];

endmodule
`default_nettype wire

@@ rtl/core/qau_div.sv @@
`default_nettype none
module qau_div
    import qau_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [SS_W-1:0]  den,
    input  wire logic             neg,
    output unit_stat_t            stat,
    output logic signed [Q_W-1:0] quo,
    output logic                  sat
);

    logic [SS_W-1:0]  den_reg;
    logic [SS_W-1:0]  rem_reg;
    logic [QB_W-1:0]  low_reg;
    logic [QB_W-1:0]  q_reg;
    logic             over_reg;
    logic             neg_reg;
    logic [DV_CW-1:0] cnt_reg;
    logic             done_reg;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] rem_diff;
    logic             ge;
    logic [QB_W:0]    q_inc;
    logic [QB_W-1:0]  q_rnd;
    logic [QB_W-1:0]  limit;
    logic [QB_W-1:0]  mag;

    // Restoring step: shift in one numerator bit, subtract if it fits
    assign rem_sh   = {rem_reg, low_reg[QB_W-1]};
    assign ge       = rem_sh >= {1'b0, den_reg};
    assign rem_diff = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg  <= den;
            rem_reg  <= SS_W'(num[NUM_W-1:QB_W]);
            low_reg  <= num[QB_W-1:0];
            q_reg    <= '0;
            over_reg <= REM_W'(num[NUM_W-1:QB_W]) >= REM_W'(den);
            neg_reg  <= neg;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? rem_diff[SS_W-1:0] : rem_sh[SS_W-1:0];
            low_reg <= {low_reg[QB_W-2:0], 1'b0};
            q_reg   <= {q_reg[QB_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= DV_CW'(QB_W);
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == DV_CW'(1));
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - DV_CW'(1);
            end
        end
    end

    // Round magnitude half away from zero, then clamp
    always_comb
    begin
        q_inc = {1'b0, q_reg} + (QB_W+1)'(1);
        q_rnd = q_inc[QB_W:1];
        limit = neg_reg ? QB_W'({1'b1, {(Q_W-1){1'b0}}}) : QB_W'(Q_MAX);
        sat   = over_reg || (q_rnd > limit);
        mag   = sat ? limit : q_rnd;
        quo   = neg_reg ? -$signed(mag[Q_W-1:0]) : $signed(mag[Q_W-1:0]);
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

endmodule
`default_nettype wire

@@ rtl/core/quaternion_arith_unit_core.sv @@
// Reciprocal and normalize run the 34-step quotient unit once per component, and normalize
// runs the root unit first; on a zero sum of squares both skip them.
// One item at a time: s_tready is high only while the sequencer is idle, so the next item
// is taken at the earliest after the result beat is loaded into the output register,
// and m_tready stalls hold it back further.
// rst_n (async, active low) clears the accumulator to zero and the control state.
`default_nettype none
`include "quaternion_arith_unit_core_defines.svh"
module quaternion_arith_unit_core
    import qau_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // arg_r, arg_i, arg_j, arg_k, factor
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // req_type
    input  wire logic [OP_W-1:0]       s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // res_r, res_i, res_j, res_k, mod_sq, zero pad
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // sat_flag, div_zero
    output logic [1:0]                 m_tuser
);

    state_t                 state_reg, state_next;
    job_t                   job_reg, job_next;
    logic [1:0]             comp_reg, comp_next;
    logic [1:0]             cnt_reg, cnt_next;
    op_t                    op_reg;
    logic signed [Q_W-1:0]  acc_q [4];
    logic signed [Q_W-1:0]  arg_q [4];
    logic signed [Q_W-1:0]  nq [4];
    logic signed [Q_W-1:0]  factor_reg;
    logic [SS_W-1:0]        ss_reg;
    logic [MOD_W-1:0]       mod_reg;
    logic                   sat_reg;
    logic                   dz_reg;
    logic                   m_tvalid_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg;
    logic [1:0]             out_user_reg;

    mac_ctl_t               mac_ctl;
    logic signed [Q_W-1:0]  mac_a, mac_b;
    logic signed [ACC_W-1:0] mac_acc;
    logic [1:0]             last_idx;
    logic                   term_last;
    logic                   sum_zero;
    logic                   sqrt_start, div_start;
    unit_stat_t             sqrt_stat, div_stat;
    logic [Q_W-1:0]         sqrt_root;
    logic signed [Q_W-1:0]  div_quo;
    logic                   div_sat;
    logic                   accept, out_load;

    logic [ACC_W-1:0]       rnd_half;
    logic signed [ACC_W-1:0] rnd_v, rnd_sh;
    logic                   rnd_sat_pos, rnd_sat_neg;
    logic signed [Q_W-1:0]  rnd_val;
    logic [ACC_W-1:0]       ms, ms_sh;
    logic [MOD_W-1:0]       mod_val;

    logic signed [Q_W-1:0]  dv_x;
    logic [Q_W-1:0]         dv_abs;
    logic [NUM_W-1:0]       dv_num;
    logic [SS_W-1:0]        dv_den;
    logic [SS_W-1:0]        dv_len;
    logic                   dv_neg;

    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);
    assign sum_zero = (mac_acc == '0);

    // Terms per component of the current job
    always_comb
    begin
        last_idx = 2'd3;
        if (job_reg == JOB_COMP)
        begin
            if (op_reg == OP_ADD_SCALED)
            begin
                last_idx = 2'd1;
            end
            else if (op_reg == OP_SCALE)
            begin
                last_idx = 2'd0;
            end
        end
        term_last = (cnt_reg == last_idx);
    end

    // Next state and sequencer counters
    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        comp_next  = comp_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    comp_next = 2'd0;
                    cnt_next  = 2'd0;
                    unique case (op_t'(s_tuser))
                        OP_LOAD, OP_CONJ:
                        begin
                            state_next = S_SIMPLE;
                        end
                        OP_RECIP, OP_NORM:
                        begin
                            state_next = S_MAC_ISSUE;
                            job_next   = JOB_SSOLD;
                        end
                        default:
                        begin
                            state_next = S_MAC_ISSUE;
                            job_next   = JOB_COMP;
                        end
                    endcase
                end
            end
            S_SIMPLE:
            begin
                state_next = S_MAC_ISSUE;
                job_next   = JOB_MOD;
                cnt_next   = 2'd0;
            end
            S_MAC_ISSUE:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (term_last)
                begin
                    state_next = S_MAC_WAIT;
                end
            end
            S_MAC_WAIT:
            begin
                state_next = S_MAC_DONE;
            end
            S_MAC_DONE:
            begin
                cnt_next = 2'd0;
                unique case (job_reg)
                    JOB_COMP:
                    begin
                        state_next = S_MAC_ISSUE;
                        comp_next  = comp_reg + 2'd1;
                        if (comp_reg == 2'd3)
                        begin
                            job_next = JOB_MOD;
                        end
                    end
                    JOB_SSOLD:
                    begin
                        comp_next = 2'd0;
                        if (sum_zero)
                        begin
                            state_next = S_MAC_ISSUE;
                            job_next   = JOB_MOD;
                        end
                        else if (op_reg == OP_RECIP)
                        begin
                            state_next = S_DIV_START;
                        end
                        else
                        begin
                            state_next = S_SQRT;
                        end
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_SQRT:
            begin
                if (sqrt_stat.done)
                begin
                    state_next = S_DIV_START;
                end
            end
            S_DIV_START:
            begin
                state_next = S_DIV_RUN;
            end
            S_DIV_RUN:
            begin
                if (div_stat.done)
                begin
                    comp_next = comp_reg + 2'd1;
                    if (comp_reg == 2'd3)
                    begin
                        state_next = S_MAC_ISSUE;
                        job_next   = JOB_MOD;
                        cnt_next   = 2'd0;
                    end
                    else
                    begin
                        state_next = S_DIV_START;
                    end
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Unit controls and handshake outputs
    always_comb
    begin
        s_tready        = (state_reg == S_IDLE);
        mac_ctl.issue   = (state_reg == S_MAC_ISSUE);
        mac_ctl.start   = (state_reg == S_MAC_ISSUE) && (cnt_reg == 2'd0);
        mac_ctl.neg     = 1'b0;
        mac_a           = '0;
        mac_b           = '0;
        sqrt_start      = (state_reg == S_MAC_DONE) && (job_reg == JOB_SSOLD)
                          && !sum_zero && (op_reg == OP_NORM);
        div_start       = (state_reg == S_DIV_START);
        unique case (job_reg)
            JOB_SSOLD:
            begin
                mac_a = acc_q[cnt_reg];
                mac_b = acc_q[cnt_reg];
            end
            JOB_MOD:
            begin
                mac_a = nq[cnt_reg];
                mac_b = nq[cnt_reg];
            end
            JOB_COMP:
            begin
                unique case (op_reg)
                    OP_ADD_SCALED:
                    begin
                        mac_a = (cnt_reg == 2'd0) ? acc_q[comp_reg] : arg_q[comp_reg];
                        mac_b = (cnt_reg == 2'd0) ? FIX_ONE : factor_reg;
                    end
                    OP_SCALE:
                    begin
                        mac_a = acc_q[comp_reg];
                        mac_b = factor_reg;
                    end
                    OP_MUL:
                    begin
                        mac_a       = acc_q[HAM_IA[comp_reg][cnt_reg]];
                        mac_b       = arg_q[HAM_IB[comp_reg][cnt_reg]];
                        mac_ctl.neg = HAM_NEG[comp_reg][cnt_reg];
                    end
                    OP_PREMUL:
                    begin
                        mac_a       = arg_q[HAM_IA[comp_reg][cnt_reg]];
                        mac_b       = acc_q[HAM_IB[comp_reg][cnt_reg]];
                        mac_ctl.neg = HAM_NEG[comp_reg][cnt_reg];
                    end
                    default:
                    begin
                        mac_a = '0;
                        mac_b = '0;
                    end
                endcase
            end
            default:
            begin
                mac_a = '0;
                mac_b = '0;
            end
        endcase
    end

    // Round half up and saturate the product sum; round and clamp the squared modulus
    always_comb
    begin
        rnd_half    = ACC_W'(1) << (FRAC_BITS - 1);
        rnd_v       = mac_acc + $signed(rnd_half);
        rnd_sh      = rnd_v >>> FRAC_BITS;
        rnd_sat_pos = !rnd_sh[ACC_W-1] && (|rnd_sh[ACC_W-2:Q_W-1]);
        rnd_sat_neg = rnd_sh[ACC_W-1] && !(&rnd_sh[ACC_W-2:Q_W-1]);
        if (rnd_sat_pos)
        begin
            rnd_val = Q_MAX;
        end
        else if (rnd_sat_neg)
        begin
            rnd_val = Q_MIN;
        end
        else
        begin
            rnd_val = rnd_sh[Q_W-1:0];
        end
        ms      = $unsigned(mac_acc) + rnd_half;
        ms_sh   = ms >> FRAC_BITS;
        mod_val = (|ms_sh[ACC_W-1:MOD_W]) ? '1 : ms_sh[MOD_W-1:0];
    end

    // Quotient operands for the current component
    always_comb
    begin
        dv_x   = acc_q[comp_reg];
        dv_abs = dv_x[Q_W-1] ? Q_W'(-dv_x) : Q_W'(dv_x);
        dv_len = ss_reg[SS_W-1] ? (SS_W'(1) << Q_W) : SS_W'(sqrt_root);
        if (op_reg == OP_RECIP)
        begin
            dv_num = NUM_W'(dv_abs) << (2 * FRAC_BITS + 1);
            dv_den = ss_reg;
            dv_neg = (dv_x[Q_W-1] != (comp_reg != 2'd0)) && (dv_abs != '0);
        end
        else
        begin
            dv_num = NUM_W'(dv_abs) << (FRAC_BITS + 1);
            dv_den = dv_len;
            dv_neg = dv_x[Q_W-1];
        end
    end

    qau_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .op_a  (mac_a),
        .op_b  (mac_b),
        .acc   (mac_acc)
    );

    qau_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .x     (mac_acc[PROD_W-1:0]),
        .stat  (sqrt_stat),
        .root  (sqrt_root)
    );

    qau_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (dv_num),
        .den   (dv_den),
        .neg   (dv_neg),
        .stat  (div_stat),
        .quo   (div_quo),
        .sat   (div_sat)
    );

    // Control state and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            job_reg      <= JOB_COMP;
            comp_reg     <= 2'd0;
            cnt_reg      <= 2'd0;
            m_tvalid_reg <= 1'b0;
            for (int c = 0; c < 4; c++)
            begin
                acc_q[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            comp_reg  <= comp_next;
            cnt_reg   <= cnt_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
                for (int c = 0; c < 4; c++)
                begin
                    acc_q[c] <= nq[c];
                end
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Operands, working quaternion, flags and output beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= op_t'(s_tuser);
            factor_reg <= s_tdata[4*Q_W +: Q_W];
            sat_reg    <= 1'b0;
            dz_reg     <= 1'b0;
            for (int c = 0; c < 4; c++)
            begin
                arg_q[c] <= s_tdata[c*Q_W +: Q_W];
                nq[c]    <= (op_t'(s_tuser) == OP_LOAD) ? s_tdata[c*Q_W +: Q_W] : acc_q[c];
            end
        end
        if ((state_reg == S_SIMPLE) && (op_reg == OP_CONJ))
        begin
            for (int c = 1; c < 4; c++)
            begin
                if (acc_q[c] == Q_MIN)
                begin
                    nq[c]   <= Q_MAX;
                    sat_reg <= 1'b1;
                end
                else
                begin
                    nq[c] <= -acc_q[c];
                end
            end
        end
        if (state_reg == S_MAC_DONE)
        begin
            unique case (job_reg)
                JOB_COMP:
                begin
                    nq[comp_reg] <= rnd_val;
                    if (rnd_sat_pos || rnd_sat_neg)
                    begin
                        sat_reg <= 1'b1;
                    end
                end
                JOB_SSOLD:
                begin
                    ss_reg <= mac_acc[SS_W-1:0];
                    if (sum_zero && (op_reg == OP_RECIP))
                    begin
                        dz_reg <= 1'b1;
                    end
                end
                default:
                begin
                    mod_reg <= mod_val;
                end
            endcase
        end
        if ((state_reg == S_DIV_RUN) && div_stat.done)
        begin
            nq[comp_reg] <= div_quo;
            if (div_sat)
            begin
                sat_reg <= 1'b1;
            end
        end
        if (out_load)
        begin
            out_data_reg <= OUT_DATA_W'({mod_reg, nq[3], nq[2], nq[1], nq[0]});
            out_user_reg <= {dz_reg, sat_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    `QAU_ASSERT_NEXT(a_accept_leaves_idle, accept, state_reg != S_IDLE, "accept did not start work")
    `QAU_ASSERT_IMP(a_dz_without_sat, m_tvalid && m_tuser[1], !m_tuser[0], "div_zero with sat_flag")
    `QAU_ASSERT_IMP(a_units_quiet_idle, state_reg == S_IDLE,
                    !sqrt_stat.busy && !div_stat.busy, "iterative unit busy while idle")
    `QAU_ASSERT_IMP(a_div_done_in_run, div_stat.done, state_reg == S_DIV_RUN, "stray quotient")
    `QAU_ASSERT_IMP(a_sqrt_done_in_sqrt, sqrt_stat.done, state_reg == S_SQRT, "stray root")

endmodule
`default_nettype wire

@@ sim/tb_quaternion_arith_unit_core.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_quaternion_arith_unit_core;
    import qau_pkg::*;

    localparam int ONE_Q = 32'sh1000_0000;
    localparam int N_RANDOM = 1250;

    typedef struct {
        op_t op;
        int  arg [4];
        int  fac;
    } quat_req_t;

    typedef struct {
        int          comp [4];
        logic [35:0] mod;
        bit          sat;
        bit          dz;
    } quat_res_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // arg_r, arg_i, arg_j, arg_k, factor
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    // req_type
    logic [OP_W-1:0]       s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // res_r, res_i, res_j, res_k, mod_sq, zero pad
    logic [OUT_DATA_W-1:0] m_tdata;
    // sat_flag, div_zero
    logic [1:0]            m_tuser;

    quat_req_t pending_reqs [$];
    quat_res_t expected_res [$];
    int        acc_q [4] = '{0, 0, 0, 0};
    bit        sat_seen;
    bit        failed = 1'b0;
    bit        stim_done = 1'b0;
    int        gap_left = 0;
    int        burst_left = 1;
    int        stall_mode = 0;
    int        stall_cnt = 0;

    quaternion_arith_unit_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic signed [127:0] widen(input int x);
        logic signed [127:0] w;
        begin
            w = x;
            return w;
        end
    endfunction

    // Round half up by the fraction width, clamp to 32 bits
    function automatic int round_clamp(input logic signed [127:0] v);
        logic signed [127:0] t;
        begin
            t = (v + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            if (t > 128'sd2147483647)
            begin
                sat_seen = 1'b1;
                return 32'sh7fff_ffff;
            end
            if (t < -128'sd2147483648)
            begin
                sat_seen = 1'b1;
                return 32'sh8000_0000;
            end
            return int'(t[31:0]);
        end
    endfunction

    // Quotient of magnitude a * 2^(sh-1) / d, rounded away from zero, clamped
    function automatic int quot_round(input logic [63:0] a, input int sh,
                                      input logic [127:0] d, input bit neg);
        logic [127:0] n;
        logic [127:0] qt;
        logic [40:0]  q;
        logic [40:0]  lim;
        begin
            n = {64'd0, a} << sh;
            qt = n / d;
            q = ({1'b0, qt[39:0]} + 41'd1) >> 1;
            lim = neg ? 41'h0_8000_0000 : 41'h0_7fff_ffff;
            if ((|qt[127:40]) || q > lim)
            begin
                q = lim;
                sat_seen = 1'b1;
            end
            return neg ? int'(-q[31:0]) : int'(q[31:0]);
        end
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        begin
            res = 64'd0;
            bitv = 64'd1 << 62;
            while (bitv > x)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (x >= res + bitv)
                begin
                    x = x - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        end
    endfunction

    function automatic logic [127:0] norm_sq(input int q [4]);
        logic signed [127:0] s;
        begin
            s = 0;
            for (int n = 0; n < 4; n++)
                s = s + widen(q[n]) * widen(q[n]);
            return s;
        end
    endfunction

    function automatic logic [63:0] magnitude(input int x);
        logic signed [127:0] w;
        begin
            w = widen(x);
            return (w < 0) ? 64'(-w) : 64'(w);
        end
    endfunction

    // Hamilton product a (x) b
    function automatic void hamilton_mul(input int a [4], input int b [4], output int o [4]);
        logic signed [127:0] a0, a1, a2, a3, b0, b1, b2, b3;
        begin
            a0 = widen(a[0]); a1 = widen(a[1]); a2 = widen(a[2]); a3 = widen(a[3]);
            b0 = widen(b[0]); b1 = widen(b[1]); b2 = widen(b[2]); b3 = widen(b[3]);
            o[0] = round_clamp(a0 * b0 - a1 * b1 - a2 * b2 - a3 * b3);
            o[1] = round_clamp(a0 * b1 + a1 * b0 + a2 * b3 - a3 * b2);
            o[2] = round_clamp(a0 * b2 + a2 * b0 + a3 * b1 - a1 * b3);
            o[3] = round_clamp(a0 * b3 + a3 * b0 + a1 * b2 - a2 * b1);
        end
    endfunction

    // Apply one request to the accumulator copy and return the result beat
    function automatic quat_res_t apply_request(input quat_req_t rq);
        quat_res_t           res;
        int                  nq [4];
        logic [127:0]        ss;
        logic [127:0]        ms;
        logic [63:0]         len;
        logic [63:0]         a;
        begin
            sat_seen = 1'b0;
            res.dz = 1'b0;
            nq = acc_q;
            case (rq.op)
                OP_LOAD:
                    nq = rq.arg;
                OP_ADD_SCALED:
                    for (int n = 0; n < 4; n++)
                        nq[n] = round_clamp(widen(acc_q[n]) * widen(ONE_Q)
                                            + widen(rq.arg[n]) * widen(rq.fac));
                OP_MUL:
                    hamilton_mul(acc_q, rq.arg, nq);
                OP_PREMUL:
                    hamilton_mul(rq.arg, acc_q, nq);
                OP_CONJ:
                    for (int n = 1; n < 4; n++)
                    begin
                        if (acc_q[n] == 32'sh8000_0000)
                        begin
                            nq[n] = 32'sh7fff_ffff;
                            sat_seen = 1'b1;
                        end
                        else
                            nq[n] = -acc_q[n];
                    end
                OP_SCALE:
                    for (int n = 0; n < 4; n++)
                        nq[n] = round_clamp(widen(acc_q[n]) * widen(rq.fac));
                OP_RECIP:
                begin
                    ss = norm_sq(acc_q);
                    if (ss == 0)
                        res.dz = 1'b1;
                    else
                        for (int n = 0; n < 4; n++)
                        begin
                            a = magnitude(acc_q[n]);
                            nq[n] = quot_round(a, 2 * FRAC_BITS + 1, ss,
                                               ((acc_q[n] < 0) != (n > 0)) && a != 0);
                        end
                end
                default:
                begin
                    ss = norm_sq(acc_q);
                    if (ss != 0)
                    begin
                        len = (ss[127:64] != 0) ? 64'd1 << 32 : root_floor(ss[63:0]);
                        for (int n = 0; n < 4; n++)
                            nq[n] = quot_round(magnitude(acc_q[n]), FRAC_BITS + 1,
                                               {64'd0, len}, acc_q[n] < 0);
                    end
                end
            endcase
            acc_q = nq;
            ms = (norm_sq(acc_q) + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            res.mod = (ms > 128'hf_ffff_ffff) ? 36'hf_ffff_ffff : ms[35:0];
            res.comp = nq;
            res.sat = sat_seen;
            return res;
        end
    endfunction

    task automatic add_req(input op_t op, input int r, input int i, input int j,
                           input int k, input int f);
        quat_req_t rq;
        begin
            rq.op = op;
            rq.arg = '{r, i, j, k};
            rq.fac = f;
            pending_reqs.push_back(rq);
        end
    endtask

    // Mix of full-range, near-unit and extreme values
    function automatic int rand_val();
        case ($urandom_range(0, 9))
            0, 1, 2: return int'($urandom);
            3:       return ($urandom_range(0, 1) != 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
            4:       return 0;
            5:       return int'($urandom_range(0, 255)) - 128;
            default: return int'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
        endcase
    endfunction

    // Feed request beats in bursts with random gaps
    always @(posedge clk)
    begin
        bit accepted;
        bit nv;
        accepted = s_tvalid && s_tready;
        nv = s_tvalid;
        if (rst_n)
        begin
            if (accepted)
            begin
                expected_res.push_back(apply_request(pending_reqs[0]));
                void'(pending_reqs.pop_front());
                burst_left = burst_left - 1;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    nv = 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    nv = 1'b1;
                    s_tdata <= {pending_reqs[0].fac, pending_reqs[0].arg[3],
                                pending_reqs[0].arg[2], pending_reqs[0].arg[1],
                                pending_reqs[0].arg[0]};
                    s_tuser <= pending_reqs[0].op;
                end
                else
                    nv = 1'b0;
            end
            s_tvalid <= nv;
        end
    end

    // Stall the result side on a changing pattern; check each accepted beat
    always @(posedge clk)
    begin
        quat_res_t exp_r;
        int        got [4];
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_res.size() == 0)
                begin
                    $display("%0t: unexpected result beat, actual %h", $time, m_tdata);
                    failed = 1'b1;
                end
                else
                begin
                    exp_r = expected_res.pop_front();
                    for (int n = 0; n < 4; n++)
                    begin
                        got[n] = int'(m_tdata[32*n +: 32]);
                        if (got[n] != exp_r.comp[n])
                        begin
                            $display("%0t: component %0d expected %h actual %h",
                                     $time, n, exp_r.comp[n], got[n]);
                            failed = 1'b1;
                        end
                    end
                    if (m_tdata[163:128] != exp_r.mod)
                    begin
                        $display("%0t: mod_sq expected %h actual %h",
                                 $time, exp_r.mod, m_tdata[163:128]);
                        failed = 1'b1;
                    end
                    if (m_tuser[0] != exp_r.sat)
                    begin
                        $display("%0t: sat_flag expected %b actual %b",
                                 $time, exp_r.sat, m_tuser[0]);
                        failed = 1'b1;
                    end
                    if (m_tuser[1] != exp_r.dz)
                    begin
                        $display("%0t: div_zero expected %b actual %b",
                                 $time, exp_r.dz, m_tuser[1]);
                        failed = 1'b1;
                    end
                end
            end
            stall_cnt = stall_cnt + 1;
            if (stall_cnt >= 97)
            begin
                stall_cnt = 0;
                stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 1) != 0);
                2:       m_tready <= ($urandom_range(0, 7) == 0);
                default: m_tready <= ((stall_cnt % 20) > 12);
            endcase
        end
    end

    initial
    begin
        int op;
        // Directed: extremes, every operation, zero divide and zero normalize
        add_req(OP_LOAD, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0);
        add_req(OP_SCALE, 0, 0, 0, 0, 32'sh7fff_ffff);
        add_req(OP_ADD_SCALED, 32'sh7fff_ffff, 1, -1, 32'sh8000_0000, 32'sh8000_0000);
        add_req(OP_LOAD, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0);
        add_req(OP_NORM, 0, 0, 0, 0, 0);
        add_req(OP_LOAD, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0);
        add_req(OP_CONJ, 0, 0, 0, 0, 0);
        add_req(OP_RECIP, 0, 0, 0, 0, 0);
        add_req(OP_LOAD, 0, 0, 0, 0, 0);
        add_req(OP_RECIP, 0, 0, 0, 0, 0);
        add_req(OP_NORM, 0, 0, 0, 0, 0);
        add_req(OP_LOAD, ONE_Q, ONE_Q / 2, -ONE_Q, 3, ONE_Q);
        add_req(OP_MUL, ONE_Q / 4, -ONE_Q, ONE_Q / 3, ONE_Q, 0);
        add_req(OP_PREMUL, -ONE_Q / 2, 7, ONE_Q, -ONE_Q / 5, 0);
        add_req(OP_RECIP, 0, 0, 0, 0, 0);
        add_req(OP_NORM, 0, 0, 0, 0, 0);
        add_req(OP_LOAD, 1, 0, 0, 0, 0);
        add_req(OP_RECIP, 0, 0, 0, 0, 0);
        add_req(OP_LOAD, 0, -1, 0, 0, 0);
        add_req(OP_NORM, 0, 0, 0, 0, 0);
        add_req(OP_MUL, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 0);
        add_req(OP_SCALE, 0, 0, 0, 0, 32'sh8000_0000);
        add_req(OP_ADD_SCALED, -1, 32'hffff_ffff, 0, 1, -1);
        // Random: reload now and then so the accumulator stays in a useful range
        for (int n = 0; n < N_RANDOM; n++)
        begin
            op = ($urandom_range(0, 9) == 0) ? OP_LOAD : $urandom_range(0, 7);
            add_req(op_t'(op), rand_val(), rand_val(), rand_val(), rand_val(), rand_val());
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_reqs.size() == 0 && !s_tvalid && expected_res.size() == 0);
        repeat (300) @(posedge clk);
        if (!failed && expected_res.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire
